// ===== hdl/tasp_pkg.sv =====
package tasp_pkg;

  localparam int unsigned CountWidth = 32;
  localparam int unsigned AccWidth   = CountWidth + 2;
  localparam int unsigned NumAxes    = 3;
  localparam int unsigned InDataW    = 200;
  localparam int unsigned OutDataW   = 48;

  typedef logic [CountWidth-1:0] cnt_t;
  typedef logic [AccWidth-1:0]   acc_t;

  typedef struct packed {
    logic        motion_offered;
    logic [31:0] axis_steps_x;
    logic [31:0] axis_steps_y;
    logic [31:0] axis_steps_z;
    logic [31:0] motion_total;
    logic [2:0]  motion_dirs;
    logic [31:0] tick_delay;
    logic [31:0] accum_start;
  } item_t;

  typedef struct packed {
    logic [2:0]  step_pulses;
    logic [2:0]  dir_out;
    logic [31:0] reload_value;
    logic        motion_taken;
    logic        idle_flag;
    logic        timer_stop;
  } res_t;

  function automatic cnt_t to_cnt(logic [31:0] v);
    logic [CountWidth+31:0] t;
    t = {{CountWidth{1'b0}}, v};
    return t[CountWidth-1:0];
  endfunction

  function automatic acc_t cnt_to_acc(cnt_t v);
    return {2'b00, v};
  endfunction

endpackage

// ===== hdl/three_axis_step_pulse_generator_unit.sv =====
// Three-axis step pulse generator. Each input item is one timer tick that also
// offers the next queued motion (flag in tuser). With no motion active, an
// offered motion is taken on that tick; with none offered the result reports
// idle and timer stop. Each tick yields one result item: the step bits worked
// out on the previous tick, the direction bits and the timer reload value,
// while three Bresenham accumulators advance. The block takes one item per
// clock unless the result is stalled; an item waits in the input register,
// and its result, from the combinational update, in the result register.
module three_axis_step_pulse_generator_unit (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  // axis_steps_x, axis_steps_y, axis_steps_z, motion_total, motion_dirs,
  // tick_delay, accum_start, zero fill
  input  logic [tasp_pkg::InDataW-1:0]     s_axis_tdata_i,
  // motion_offered
  input  logic                             s_axis_tuser_i,
  output logic                             m_axis_tvalid_o,
  input  logic                             m_axis_tready_i,
  // step_pulses, dir_out, reload_value, motion_taken, idle_flag, timer_stop,
  // zero fill
  output logic [tasp_pkg::OutDataW-1:0]    m_axis_tdata_o
);

  logic            in_vld_q;
  tasp_pkg::item_t in_q;
  logic            out_vld_q;
  tasp_pkg::res_t  res_q;
  tasp_pkg::res_t  res_d;
  logic            adv;
  logic            in_acc;

  assign adv             = in_vld_q && (!out_vld_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_vld_q || adv;
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;

  tasp_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (adv),
    .item_i (in_q),
    .res_o  (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_acc) begin
        in_vld_q <= 1'b1;
      end else if (adv) begin
        in_vld_q <= 1'b0;
      end
      if (adv) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      in_q.motion_offered <= s_axis_tuser_i;
      in_q.axis_steps_x   <= s_axis_tdata_i[31:0];
      in_q.axis_steps_y   <= s_axis_tdata_i[63:32];
      in_q.axis_steps_z   <= s_axis_tdata_i[95:64];
      in_q.motion_total   <= s_axis_tdata_i[127:96];
      in_q.motion_dirs    <= s_axis_tdata_i[130:128];
      in_q.tick_delay     <= s_axis_tdata_i[162:131];
      in_q.accum_start    <= s_axis_tdata_i[194:163];
    end
    if (adv) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {7'b0000000, res_q.timer_stop, res_q.idle_flag,
                            res_q.motion_taken, res_q.reload_value,
                            res_q.dir_out, res_q.step_pulses};

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_vld_q |-> s_axis_tready_o)
    else $error("input stage empty but not ready");

  a_hold_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && !m_axis_tready_i |=> out_vld_q && $stable(res_q))
    else $error("stalled result changed");

  a_stop_is_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && res_q.timer_stop |->
      res_q.idle_flag && !res_q.motion_taken && res_q.step_pulses == 3'b000)
    else $error("timer stop result malformed");

  a_taken_no_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && res_q.motion_taken |-> res_q.step_pulses == 3'b000)
    else $error("pulses on the tick a motion is taken");

endmodule

// ===== hdl/tasp_core.sv =====
module tasp_core (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             fire_i,
  input  tasp_pkg::item_t  item_i,
  output tasp_pkg::res_t   res_o
);

  logic                 active_q, active_d;
  tasp_pkg::acc_t       acc_q   [tasp_pkg::NumAxes];
  tasp_pkg::acc_t       acc_d   [tasp_pkg::NumAxes];
  tasp_pkg::cnt_t       steps_q [tasp_pkg::NumAxes];
  tasp_pkg::cnt_t       steps_d [tasp_pkg::NumAxes];
  tasp_pkg::cnt_t       total_q, total_d;
  tasp_pkg::cnt_t       ticks_q, ticks_d;
  logic [2:0]           dirs_q, dirs_d;
  logic [31:0]          delay_q, delay_d;
  logic [2:0]           pend_q, pend_d;

  always_comb begin
    tasp_pkg::acc_t sum;
    tasp_pkg::acc_t cur_acc [tasp_pkg::NumAxes];
    tasp_pkg::cnt_t cur_steps [tasp_pkg::NumAxes];
    tasp_pkg::cnt_t cur_total;
    tasp_pkg::cnt_t cur_ticks;
    logic [2:0]     cur_dirs;
    logic [31:0]    cur_delay;
    logic [2:0]     cur_pend;
    logic [2:0]     nxt_pend;
    logic           taken;

    active_d = active_q;
    total_d  = total_q;
    ticks_d  = ticks_q;
    dirs_d   = dirs_q;
    delay_d  = delay_q;
    pend_d   = pend_q;
    for (int a = 0; a < tasp_pkg::NumAxes; a++) begin
      acc_d[a]   = acc_q[a];
      steps_d[a] = steps_q[a];
    end
    res_o = '0;

    taken     = !active_q;
    cur_total = active_q ? total_q : tasp_pkg::to_cnt(item_i.motion_total);
    cur_ticks = active_q ? ticks_q : '0;
    cur_dirs  = active_q ? dirs_q  : item_i.motion_dirs;
    cur_delay = active_q ? delay_q : item_i.tick_delay;
    cur_pend  = active_q ? pend_q  : 3'b000;
    cur_steps[0] = active_q ? steps_q[0] : tasp_pkg::to_cnt(item_i.axis_steps_x);
    cur_steps[1] = active_q ? steps_q[1] : tasp_pkg::to_cnt(item_i.axis_steps_y);
    cur_steps[2] = active_q ? steps_q[2] : tasp_pkg::to_cnt(item_i.axis_steps_z);
    for (int a = 0; a < tasp_pkg::NumAxes; a++) begin
      cur_acc[a] = active_q ? acc_q[a]
                            : tasp_pkg::cnt_to_acc(tasp_pkg::to_cnt(item_i.accum_start));
    end
    nxt_pend = 3'b000;
    sum      = '0;

    if (!active_q && !item_i.motion_offered) begin
      res_o.idle_flag  = 1'b1;
      res_o.timer_stop = 1'b1;
    end else begin
      res_o.step_pulses  = cur_pend;
      res_o.dir_out      = cur_dirs;
      res_o.reload_value = cur_delay;
      res_o.motion_taken = taken;

      if (fire_i) begin
        total_d = cur_total;
        dirs_d  = cur_dirs;
        delay_d = cur_delay;
        for (int a = 0; a < tasp_pkg::NumAxes; a++) begin
          steps_d[a] = cur_steps[a];
          acc_d[a]   = cur_acc[a];
        end
      end

      if (cur_ticks != cur_total) begin
        for (int a = 0; a < tasp_pkg::NumAxes; a++) begin
          sum = cur_acc[a] + tasp_pkg::cnt_to_acc(cur_steps[a]);
          if (sum > tasp_pkg::cnt_to_acc(cur_total)) begin
            nxt_pend[a] = 1'b1;
            sum = sum - tasp_pkg::cnt_to_acc(cur_total);
          end
          if (fire_i) begin
            acc_d[a] = sum;
          end
        end
        if (fire_i) begin
          ticks_d  = cur_ticks + 1'b1;
          active_d = 1'b1;
        end
      end else begin
        res_o.idle_flag = 1'b1;
        if (fire_i) begin
          ticks_d  = cur_ticks;
          active_d = 1'b0;
        end
      end

      if (fire_i) begin
        pend_d = nxt_pend;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      total_q  <= '0;
      ticks_q  <= '0;
      dirs_q   <= '0;
      delay_q  <= '0;
      pend_q   <= '0;
      for (int a = 0; a < tasp_pkg::NumAxes; a++) begin
        acc_q[a]   <= '0;
        steps_q[a] <= '0;
      end
    end else begin
      active_q <= active_d;
      total_q  <= total_d;
      ticks_q  <= ticks_d;
      dirs_q   <= dirs_d;
      delay_q  <= delay_d;
      pend_q   <= pend_d;
      for (int a = 0; a < tasp_pkg::NumAxes; a++) begin
        acc_q[a]   <= acc_d[a];
        steps_q[a] <= steps_d[a];
      end
    end
  end

endmodule
